// ===== rtl/infix_to_postfix_converter_top_defines.svh =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top_defines
// assertion macros shared by the converter modules
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_TOP_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_TOP_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define I2P_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2P_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define I2P_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define I2P_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/i2p_pkg.sv =====
// ----------------------------------------------------------------------------
// i2p_pkg
// character codes, operator codes and shared types of the converter
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;

  typedef logic [2:0] op_code_t;

  localparam op_code_t CODE_LP  = 3'd0;
  localparam op_code_t CODE_ADD = 3'd1;
  localparam op_code_t CODE_SUB = 3'd2;
  localparam op_code_t CODE_MUL = 3'd3;
  localparam op_code_t CODE_DIV = 3'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LP    = 8'h28;
  localparam logic [7:0] CH_RP    = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_LETTER,
    CLS_OP,
    CLS_LP,
    CLS_RP,
    CLS_END,
    CLS_OTHER
  } cls_e;

  // stack request from the sequencer
  typedef struct packed {
    logic     push;
    logic     pop;
    logic     clear;
    op_code_t code;
  } stk_cmd_t;

  // stack status back to the sequencer
  typedef struct packed {
    logic     empty;
    logic     full;
    logic     lp_any;
    op_code_t top;
  } stk_stat_t;

  function automatic cls_e classify(input logic [7:0] ch);
    cls_e c;
    if (ch >= CH_0 && ch <= CH_9) c = CLS_DIGIT;
    else if (ch >= CH_A && ch <= CH_Z) c = CLS_LETTER;
    else if (ch == CH_ADD || ch == CH_SUB || ch == CH_MUL || ch == CH_DIV) c = CLS_OP;
    else if (ch == CH_LP) c = CLS_LP;
    else if (ch == CH_RP) c = CLS_RP;
    else if (ch == CH_NUL) c = CLS_END;
    else c = CLS_OTHER;
    return c;
  endfunction

  function automatic op_code_t op_code(input logic [7:0] ch);
    op_code_t c;
    if (ch == CH_ADD) c = CODE_ADD;
    else if (ch == CH_SUB) c = CODE_SUB;
    else if (ch == CH_MUL) c = CODE_MUL;
    else if (ch == CH_DIV) c = CODE_DIV;
    else c = CODE_LP;
    return c;
  endfunction

  function automatic logic [7:0] op_char(input op_code_t code);
    logic [7:0] c;
    unique case (code)
      CODE_ADD: c = CH_ADD;
      CODE_SUB: c = CH_SUB;
      CODE_MUL: c = CH_MUL;
      CODE_DIV: c = CH_DIV;
      default:  c = CH_LP;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] op_rank(input op_code_t code);
    logic [1:0] r;
    unique case (code) inside
      CODE_ADD, CODE_SUB: r = 2'd1;
      CODE_MUL, CODE_DIV: r = 2'd2;
      default:            r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/i2p_stack.sv =====
// ----------------------------------------------------------------------------
// i2p_stack
// operator stack with registered top entry and open-paren count
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_top_defines.svh"

module i2p_stack #(
  parameter int unsigned STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i2p_pkg::stk_cmd_t    cmd_i,
  output i2p_pkg::stk_stat_t   stat_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [CntW-1:0] Full = CntW'(STACK_DEPTH);

  i2p_pkg::op_code_t mem_q [STACK_DEPTH];

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] lp_cnt_q, lp_cnt_d;
  logic [CntW-1:0] count_m1, count_m2;
  logic [IdxW-1:0] wr_idx, below_idx;
  logic            empty, full, do_push, do_pop;
  i2p_pkg::op_code_t top_q;

  assign count_m1  = count_q - 1'b1;
  assign count_m2  = count_q - 2'd2;
  assign below_idx = count_m2[IdxW-1:0];
  assign wr_idx    = count_q[IdxW-1:0];
  assign empty     = (count_q == '0);
  assign full      = (count_q == Full);
  assign do_push   = cmd_i.push && !full;
  assign do_pop    = cmd_i.pop && !empty && !cmd_i.clear && !do_push;

  always_comb begin
    count_d  = count_q;
    lp_cnt_d = lp_cnt_q;
    if (cmd_i.clear) begin
      count_d  = '0;
      lp_cnt_d = '0;
    end else if (do_push) begin
      count_d = count_q + 1'b1;
      if (cmd_i.code == i2p_pkg::CODE_LP) lp_cnt_d = lp_cnt_q + 1'b1;
    end else if (do_pop) begin
      count_d = count_m1;
      if (top_q == i2p_pkg::CODE_LP) lp_cnt_d = lp_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      lp_cnt_q <= '0;
    end else begin
      count_q  <= count_d;
      lp_cnt_q <= lp_cnt_d;
    end
  end

  // top entry kept in a register: a push loads it, a pop reads the entry below
  always_ff @(posedge clk_i) begin
    if (do_push && !cmd_i.clear) begin
      mem_q[wr_idx] <= cmd_i.code;
      top_q         <= cmd_i.code;
    end else if (do_pop) begin
      top_q <= mem_q[below_idx];
    end
  end

  assign stat_o.empty  = empty;
  assign stat_o.full   = full;
  assign stat_o.lp_any = (lp_cnt_q != '0);
  assign stat_o.top    = top_q;

  `I2P_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= Full, "stack count past depth")
  `I2P_ASSERT_IMP(a_lp_bound, clk_i, rst_ni, 1'b1, lp_cnt_q <= count_q, "paren count past depth")
  `I2P_ASSERT_NXT(a_full_drop, clk_i, rst_ni,
                  cmd_i.push && full && !cmd_i.clear, count_q == Full,
                  "push onto full stack grew it")

endmodule

// ===== rtl/i2p_seq.sv =====
// ----------------------------------------------------------------------------
// i2p_seq
// per-character sequencer with shared pop compare and output register
// ----------------------------------------------------------------------------
`include "infix_to_postfix_converter_top_defines.svh"

module i2p_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          ch_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_char_o,
  output logic                last_o,
  output logic                error_o,
  input  i2p_pkg::stk_stat_t  stat_i,
  output i2p_pkg::stk_cmd_t   cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SPACE = 3'd1;
  localparam logic [2:0] S_WORK  = 3'd2;
  localparam logic [2:0] S_LSP   = 3'd3;
  localparam logic [2:0] S_POPSP = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [7:0]        ch_q;
  i2p_pkg::cls_e     cls_q, cls_in, cls_sel;
  i2p_pkg::op_code_t code_q, code_in, code_sel;
  logic              in_num_q, err_q, err_new;
  logic              out_valid_q, out_last_q, out_error_q;
  logic [7:0]        out_char_q;
  logic              accept, out_free, top_op, rank_ok, pop_go;
  logic              emit, emit_last;
  logic [7:0]        emit_char;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cls_in     = i2p_pkg::classify(ch_i);
  assign code_in    = i2p_pkg::op_code(ch_i);

  // shared pop compare: new character while idle, latched one otherwise
  assign cls_sel  = (state_q == S_IDLE) ? cls_in : cls_q;
  assign code_sel = (state_q == S_IDLE) ? code_in : code_q;
  assign top_op   = !stat_i.empty && (stat_i.top != i2p_pkg::CODE_LP);
  assign rank_ok  = i2p_pkg::op_rank(stat_i.top) >= i2p_pkg::op_rank(code_sel);

  always_comb begin
    case (cls_sel)
      i2p_pkg::CLS_OP:  pop_go = top_op && rank_ok;
      i2p_pkg::CLS_RP:  pop_go = top_op;
      i2p_pkg::CLS_END: pop_go = !stat_i.empty;
      default:          pop_go = 1'b0;
    endcase
  end

  // error as it will stand after this character
  assign err_new = err_q
                 | ((((cls_in == i2p_pkg::CLS_OP) && !pop_go) || (cls_in == i2p_pkg::CLS_LP))
                    && stat_i.full)
                 | ((cls_in == i2p_pkg::CLS_RP) && !stat_i.lp_any);

  always_comb begin
    state_d   = state_q;
    emit      = 1'b0;
    emit_char = ch_q;
    emit_last = 1'b0;
    cmd_o     = '0;
    cmd_o.code = code_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = ((cls_in != i2p_pkg::CLS_DIGIT) && in_num_q) ? S_SPACE : S_WORK;
        end
      end
      S_SPACE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = i2p_pkg::CH_SPACE;
          emit_last = !((cls_q == i2p_pkg::CLS_LETTER) || pop_go || (cls_q == i2p_pkg::CLS_END));
          state_d   = S_WORK;
        end
      end
      S_WORK: begin
        case (cls_q)
          i2p_pkg::CLS_DIGIT: begin
            if (out_free) begin
              emit      = 1'b1;
              emit_last = 1'b1;
              state_d   = S_IDLE;
            end
          end
          i2p_pkg::CLS_LETTER: begin
            if (out_free) begin
              emit    = 1'b1;
              state_d = S_LSP;
            end
          end
          i2p_pkg::CLS_OP, i2p_pkg::CLS_RP, i2p_pkg::CLS_END: begin
            if (pop_go) begin
              if (out_free) begin
                emit      = 1'b1;
                emit_char = i2p_pkg::op_char(stat_i.top);
                cmd_o.pop = 1'b1;
                state_d   = S_POPSP;
              end
            end else if (cls_q == i2p_pkg::CLS_OP) begin
              cmd_o.push = 1'b1;
              state_d    = S_IDLE;
            end else if (cls_q == i2p_pkg::CLS_RP) begin
              cmd_o.pop = 1'b1;  // matching paren, if any
              state_d   = S_IDLE;
            end else if (out_free) begin
              emit        = 1'b1;
              emit_char   = i2p_pkg::CH_NL;
              emit_last   = 1'b1;
              cmd_o.clear = 1'b1;
              state_d     = S_IDLE;
            end
          end
          i2p_pkg::CLS_LP: begin
            cmd_o.push = 1'b1;
            state_d    = S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_LSP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = i2p_pkg::CH_SPACE;
          emit_last = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_POPSP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_char = i2p_pkg::CH_SPACE;
          emit_last = !(pop_go || (cls_q == i2p_pkg::CLS_END));
          state_d   = S_WORK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cls_q       <= i2p_pkg::CLS_OTHER;
      in_num_q    <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cls_q    <= cls_in;
        in_num_q <= (cls_in == i2p_pkg::CLS_DIGIT);
        err_q    <= err_new;
      end else if (cmd_o.clear) begin
        err_q <= 1'b0;
      end
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ch_q   <= ch_i;
      code_q <= code_in;
    end
    if (emit) begin
      out_char_q  <= emit_char;
      out_last_q  <= emit_last;
      out_error_q <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;
  assign error_o     = out_error_q;

  `I2P_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, out_valid_q && out_stall_i, !emit,
                  "held output beat overwritten")
  `I2P_ASSERT_NXT(a_last_idle, clk_i, rst_ni, emit && emit_last,
                  (state_q == S_IDLE) || (state_q == S_WORK),
                  "sequencer still emitting after final beat")
  `I2P_ASSERT_NXT(a_end_clears, clk_i, rst_ni, cmd_o.clear,
                  !err_q && !in_num_q && stat_i.empty, "end of expression left state behind")

endmodule

// ===== rtl/infix_to_postfix_converter_top.sv =====
// First output beat is loaded in S_SPACE or S_WORK, entered as the character is taken.
// A digit, letter or end character needs only its output beats, any other character
//   also a push, paren pop or skip step, before the next is taken; stalls delay it.
// Output stall holds the sequencer, never the held beat; input is taken only when idle.
// Reset (rst_ni, async, active low) empties the stack, clears the digit-run and
//   error flags and drops any pending output beat.
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// streaming shunting-yard converter: infix characters in, postfix text out
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top #(
  parameter int unsigned STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input character beats
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  // postfix text beats
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_char_o,
  output logic       last_o,
  output logic       error_o
);

  // stack requests and status between sequencer and operator stack
  i2p_pkg::stk_cmd_t  stk_cmd;
  i2p_pkg::stk_stat_t stk_stat;

  // sequencer: classifies each character, runs the pop loop through one
  // shared precedence compare and feeds the single output register
  i2p_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ch_i        (ch_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .last_o      (last_o),
    .error_o     (error_o),
    .stat_i      (stk_stat),
    .cmd_o       (stk_cmd)
  );

  // operator stack: one push or pop per cycle, top entry always visible,
  // overflowing pushes are dropped
  i2p_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (stk_cmd),
    .stat_o (stk_stat)
  );

endmodule

// ===== dv/infix_to_postfix_converter_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top_tb
// streams infix character beats into the converter and checks every postfix
// beat against a shunting-yard predictor kept in step with accepted input
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_top_tb;

  localparam int unsigned OP_DEPTH = i2p_pkg::STACK_DEPTH_DEF;

  // one postfix text beat as the converter should send it
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } postfix_beat_t;

  // one pending infix character; drain holds it back until all text is out
  typedef struct {
    logic [7:0] ch;
    bit         drain;
  } infix_char_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] ch_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_char_o;
  logic       last_o;
  logic       error_o;

  infix_to_postfix_converter_top #(
    .STACK_DEPTH(OP_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ch_i       (ch_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_char_o (out_char_o),
    .last_o     (last_o),
    .error_o    (error_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predictor state: operator stack, digit-run flag and sticky error
  // ---------------------------------------------------------------------------
  i2p_pkg::op_code_t ops [OP_DEPTH];
  int unsigned   op_n = 0;
  bit            in_digits = 1'b0;
  bit            sticky_err = 1'b0;
  logic [7:0]    text_q[$];          // text produced by the current character
  postfix_beat_t postfix_q[$];       // beats still owed by the converter
  int unsigned   made_n = 0;         // beats predicted so far
  int unsigned   got_n = 0;          // beats received so far
  int unsigned   fails = 0;

  // stimulus bookkeeping
  infix_char_t   pend[$];
  bit            drain_next = 1'b0;
  int unsigned   in_count = 0;       // accepted character beats
  bit            calm = 1'b0;        // no random idle bursts on either side while set

  function automatic logic [1:0] prec_of(input i2p_pkg::op_code_t code);
    if (code == i2p_pkg::CODE_MUL || code == i2p_pkg::CODE_DIV) return 2'd2;
    if (code == i2p_pkg::CODE_ADD || code == i2p_pkg::CODE_SUB) return 2'd1;
    return 2'd0;
  endfunction

  function automatic logic [7:0] sym_of(input i2p_pkg::op_code_t code);
    case (code)
      i2p_pkg::CODE_ADD: return i2p_pkg::CH_ADD;
      i2p_pkg::CODE_SUB: return i2p_pkg::CH_SUB;
      i2p_pkg::CODE_MUL: return i2p_pkg::CH_MUL;
      i2p_pkg::CODE_DIV: return i2p_pkg::CH_DIV;
      default:           return i2p_pkg::CH_LP;
    endcase
  endfunction

  // write the top operator and its trailing space, then drop it
  task automatic unstack_op();
    text_q.push_back(sym_of(ops[op_n - 1]));
    text_q.push_back(i2p_pkg::CH_SPACE);
    op_n--;
  endtask

  // a push onto a full stack is lost and flags the expression
  task automatic stack_op(input i2p_pkg::op_code_t code);
    if (op_n >= OP_DEPTH) begin
      sticky_err = 1'b1;
    end else begin
      ops[op_n] = code;
      op_n++;
    end
  endtask

  // advance the predictor by one accepted character and queue its beats
  task automatic convert_char(input logic [7:0] c);
    i2p_pkg::op_code_t code;
    logic     err_now;
    text_q = {};
    if (c >= i2p_pkg::CH_0 && c <= i2p_pkg::CH_9) begin
      text_q.push_back(c);
      in_digits = 1'b1;
    end else begin
      // any non-digit closes a digit run with a space
      if (in_digits) begin
        text_q.push_back(i2p_pkg::CH_SPACE);
        in_digits = 1'b0;
      end
      if (c >= i2p_pkg::CH_A && c <= i2p_pkg::CH_Z) begin
        text_q.push_back(c);
        text_q.push_back(i2p_pkg::CH_SPACE);
      end else if (c == i2p_pkg::CH_ADD || c == i2p_pkg::CH_SUB ||
                   c == i2p_pkg::CH_MUL || c == i2p_pkg::CH_DIV) begin
        case (c)
          i2p_pkg::CH_ADD: code = i2p_pkg::CODE_ADD;
          i2p_pkg::CH_SUB: code = i2p_pkg::CODE_SUB;
          i2p_pkg::CH_MUL: code = i2p_pkg::CODE_MUL;
          default:         code = i2p_pkg::CODE_DIV;
        endcase
        while (op_n != 0 && ops[op_n - 1] != i2p_pkg::CODE_LP &&
               prec_of(ops[op_n - 1]) >= prec_of(code))
          unstack_op();
        stack_op(code);
      end else if (c == i2p_pkg::CH_LP) begin
        stack_op(i2p_pkg::CODE_LP);
      end else if (c == i2p_pkg::CH_RP) begin
        while (op_n != 0 && ops[op_n - 1] != i2p_pkg::CODE_LP)
          unstack_op();
        // no open paren left: the stack was emptied and the expression is bad
        if (op_n != 0) op_n--;
        else sticky_err = 1'b1;
      end else if (c == i2p_pkg::CH_NUL) begin
        while (op_n != 0)
          unstack_op();
        text_q.push_back(i2p_pkg::CH_NL);
      end
    end
    // the end character still reports the flag as it was before the clear
    err_now = sticky_err;
    if (c == i2p_pkg::CH_NUL) begin
      op_n = 0;
      in_digits = 1'b0;
      sticky_err = 1'b0;
    end
    foreach (text_q[k]) begin
      postfix_q.push_back('{text_q[k], k == text_q.size() - 1, err_now});
      made_n++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // input driver: offers pending characters, idles in random bursts
  // ---------------------------------------------------------------------------
  int unsigned gap_n = 0;

  always @(posedge clk_i) begin : drive_chars
    logic        nxt_valid;
    logic [7:0]  nxt_ch;
    infix_char_t nxt_item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      ch_i       <= 8'h00;
    end else begin
      nxt_valid = in_valid_i;
      nxt_ch    = ch_i;
      if (in_valid_i && !in_stall_o) begin
        convert_char(ch_i);
        in_count <= in_count + 1;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_n != 0) begin
          gap_n--;
        end else if (pend.size() != 0 && !(pend[0].drain && made_n != got_n)) begin
          // a gap burst covers this cycle and is then counted down in gap_n
          if (!calm && $urandom_range(0, 7) == 0) begin
            gap_n = $urandom_range(0, 18);
          end else begin
            nxt_item  = pend.pop_front();
            nxt_valid = 1'b1;
            nxt_ch    = nxt_item.ch;
          end
        end
      end
      in_valid_i <= nxt_valid;
      ch_i       <= nxt_ch;
      // quiet tail at the end, and a quiet stretch every 128 beats
      calm <= (pend.size() < 50) || (in_count[6:5] == 2'b11);
    end
  end

  // ---------------------------------------------------------------------------
  // output side: random stall bursts plus one long hold-off that backs the
  // converter up until it refuses input
  // ---------------------------------------------------------------------------
  int unsigned stall_n = 0;
  int unsigned hold_n = 0;
  bit          held = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_n != 0) begin
      hold_n--;
      out_stall_i <= 1'b1;
    end else if (!held && in_count >= 120) begin
      held = 1'b1;
      hold_n = 399;
      out_stall_i <= 1'b1;
    end else if (stall_n != 0) begin
      stall_n--;
      out_stall_i <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_n = $urandom_range(0, 18);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every accepted postfix beat against the oldest owed beat
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_beats
    postfix_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_n <= got_n + 1;
      if (postfix_q.size() == 0) begin
        $error("unexpected beat: out_char %h last %b error %b",
               out_char_o, last_o, error_o);
        fails++;
      end else begin
        want = postfix_q.pop_front();
        if (out_char_o !== want.ch) begin
          $error("out_char: expected %h, got %h", want.ch, out_char_o);
          fails++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %b, got %b", want.last, last_o);
          fails++;
        end
        if (error_o !== want.err) begin
          $error("error: expected %b, got %b", want.err, error_o);
          fails++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  task automatic put(input logic [7:0] c);
    pend.push_back('{c, drain_next});
    drain_next = 1'b0;
  endtask

  task automatic put_operator();
    case ($urandom_range(0, 3))
      0:       put(i2p_pkg::CH_ADD);
      1:       put(i2p_pkg::CH_SUB);
      2:       put(i2p_pkg::CH_MUL);
      default: put(i2p_pkg::CH_DIV);
    endcase
  endtask

  // a letter or a run of one to three digits
  task automatic put_operand();
    int unsigned n;
    if ($urandom_range(0, 1) == 0) begin
      put(8'($urandom_range(i2p_pkg::CH_A, i2p_pkg::CH_Z)));
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) put(8'($urandom_range(i2p_pkg::CH_0, i2p_pkg::CH_9)));
    end
  endtask

  // mostly well-formed expressions, some nested past the stack, some noise
  task automatic put_expression();
    int unsigned kind;
    int unsigned terms;
    int unsigned open;
    int unsigned n;
    kind = $urandom_range(0, 19);
    open = 0;
    if (kind < 15) begin
      terms = $urandom_range(1, 6);
      for (int t = 0; t < terms; t++) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) put(i2p_pkg::CH_LP);
        open += n;
        put_operand();
        if (open != 0 && $urandom_range(0, 2) == 0) begin
          n = $urandom_range(1, open);
          repeat (n) put(i2p_pkg::CH_RP);
          open -= n;
        end
        if (t != terms - 1) put_operator();
      end
      repeat (open) put(i2p_pkg::CH_RP);
      // broken tail now and then: a stray closer or a junk byte
      if ($urandom_range(0, 9) == 0) put(i2p_pkg::CH_RP);
      if ($urandom_range(0, 9) == 0) put(8'($urandom_range(0, 255)));
    end else if (kind < 17) begin
      // deep nesting around the stack limit, closers may miss or overshoot
      open = $urandom_range(13, 20);
      repeat (open) put(i2p_pkg::CH_LP);
      put_operand();
      put_operator();
      put_operand();
      n = $urandom_range(0, open + 1);
      repeat (n) put(i2p_pkg::CH_RP);
    end else begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        if ($urandom_range(0, 1) == 0) begin
          put(8'($urandom_range(0, 255)));
        end else begin
          case ($urandom_range(0, 3))
            0:       put(i2p_pkg::CH_LP);
            1:       put(i2p_pkg::CH_RP);
            2:       put_operator();
            default: put_operand();
          endcase
        end
      end
    end
    put(i2p_pkg::CH_NUL);
  endtask

  // ---------------------------------------------------------------------------
  // sequence: reset, directed expression, random expressions, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin : run_sequence
    logic [7:0] intro [17];
    int unsigned target;
    // digits ending on an operator, all operators, letters at both ends of
    // the range, a stray closer, ignored bytes, a digit run ended by the end
    intro = '{"9", "0", i2p_pkg::CH_ADD, "A", i2p_pkg::CH_MUL, i2p_pkg::CH_LP, "Z",
              i2p_pkg::CH_SUB, "1", i2p_pkg::CH_RP, i2p_pkg::CH_DIV, "5", i2p_pkg::CH_RP,
              8'hFF, "a", "7", i2p_pkg::CH_NUL};
    foreach (intro[i]) put(intro[i]);
    // let the directed text come out before the random part starts
    drain_next = 1'b1;
    target = pend.size() + 480;
    while (pend.size() < target) begin
      if (pend.size() > 250 && pend.size() < 270) drain_next = 1'b1;
      put_expression();
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pend.size() != 0 || in_valid_i) @(posedge clk_i);
    while (made_n != got_n) @(posedge clk_i);
    // catch any beat sent after the last owed one
    repeat (40) @(posedge clk_i);

    if (fails == 0) begin
      $display("infix_to_postfix_converter_top: match");
    end else begin
      $display("infix_to_postfix_converter_top: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #(8_000_000);
    $display("infix_to_postfix_converter_top: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/i2p_pkg.sv
rtl/i2p_stack.sv
rtl/i2p_seq.sv
rtl/infix_to_postfix_converter_top.sv
dv/infix_to_postfix_converter_top_tb.sv
